@@ hw/rtl/bta_pkg.sv @@
// Shared types, constants and helper functions of the boundary-tag heap allocator.
// Depends on nothing; bta_ctrl and the top level import it.
`default_nettype none
package bta_pkg;

    localparam int ARENA_UNITS = 4096;
    localparam int AW          = 12;     // unit index width
    localparam int NUM_BINS    = 100;
    localparam int BIN_TOTAL   = 2 * NUM_BINS;
    localparam int BW          = 8;      // bin index width
    localparam int UB_SHIFT    = 4;      // log2 of bytes per unit
    localparam int PAGE_UNITS  = 256;
    localparam int MW          = 13;     // unit count width (bytes rounded up)
    localparam int SPLIT_SLACK = 4;
    localparam int LEAD_MIN    = 3;

    typedef enum logic [1:0] {
        TS_FREE  = 2'd0,
        TS_BIN   = 2'd1,
        TS_ALLOC = 2'd2,
        TS_END   = 2'd3
    } t_tstate;

    typedef struct packed {
        logic          pc;
        t_tstate       st;
        logic [AW-1:0] size;
    } t_tag;

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOMEM = 2'd1;
    localparam logic [1:0] STAT_BAD   = 2'd2;

    typedef struct packed {
        logic [1:0]    kind;
        logic [15:0]   bytes;
        logic          contig;
        logic [AW-1:0] addr;
    } t_req;

    typedef struct packed {
        logic [1:0]    status;
        logic [AW-1:0] data;
        logic [15:0]   usable;
    } t_res;

    typedef struct packed {
        logic          re;
        logic [AW-1:0] ra;
        logic          we;
        logic [AW-1:0] wa;
        t_tag          wd;
    } t_tag_cmd;

    typedef struct packed {
        logic          re;
        logic [AW-1:0] ra;
        logic          we;
        logic [AW-1:0] wa;
        logic [AW-1:0] wd;
    } t_link_cmd;

    typedef struct packed {
        logic          re;
        logic [BW-1:0] ra;
        logic          we;
        logic [BW-1:0] wa;
        logic [AW-1:0] wd;
    } t_head_cmd;

    function automatic t_tag mk_tag(input logic pc, input t_tstate st,
                                    input logic [AW-1:0] size);
        t_tag t;
        t.pc   = pc;
        t.st   = st;
        t.size = size;
        return t;
    endfunction

    function automatic t_tag tag_reset(input logic [AW-1:0] a);
        t_tag t;
        t = mk_tag(1'b0, TS_FREE, '0);
        if (a == '0) begin
            t = mk_tag(1'b0, TS_END, AW'(1));
        end else if (a == AW'(1) || a == AW'(ARENA_UNITS - 2)) begin
            t = mk_tag(1'b0, TS_FREE, AW'(ARENA_UNITS - 2));
        end else if (a == AW'(ARENA_UNITS - 1)) begin
            t = mk_tag(1'b0, TS_END, '0);
        end
        return t;
    endfunction

    // usable bytes of a span: (size - 2) units, low 16 bits
    function automatic logic [15:0] usable_of(input logic [AW-1:0] size);
        logic [15:0] u;
        u = {{(16-AW){1'b0}}, size} - 16'd2;
        return u << UB_SHIFT;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bta_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
// Used for the tag, bin link and bin head stores; no dependencies.
`default_nettype none
module bta_ram #(
    parameter int W = 16,
    parameter int D = 4096,
    parameter int A = $clog2(D)
) (
    input  wire logic         i_clk,
    input  wire logic         i_we,
    input  wire logic [A-1:0] i_wa,
    input  wire logic [W-1:0] i_wd,
    input  wire logic         i_re,
    input  wire logic [A-1:0] i_ra,
    output logic      [W-1:0] o_rd
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            o_rd <= r_mem[i_ra];
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/bta_ctrl.sv @@
// Allocator sequencer: bin pops, span scans, splits, releases and coalescing.
// Drives the tag, link and head memories; uses bta_pkg.
`default_nettype none
module bta_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    input  wire bta_pkg::t_req     i_req,
    input  wire logic              i_cfg_we,
    input  wire logic [7:0]        i_cfg_wdata,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output bta_pkg::t_res          o_res,
    output bta_pkg::t_tag_cmd      o_tag_cmd,
    input  wire bta_pkg::t_tag     i_tag_q,
    output bta_pkg::t_link_cmd     o_link_cmd,
    input  wire logic [11:0]       i_link_q,
    output bta_pkg::t_head_cmd     o_head_cmd,
    input  wire logic [11:0]       i_head_q
);
    import bta_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DONE,
        S_POP_H, S_POP_L, S_POP_T, S_POP_E,
        S_SC_INIT, S_SCAN, S_FAIL,
        S_LEAD0, S_LEAD1, S_TS0, S_TS1, S_TS2, S_TS3,
        S_CO_H, S_CO_L,
        S_RL0, S_RL1, S_RL2, S_RLW,
        S_V_P, S_V_E, S_V_B, S_F_H, S_F_E
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic [AW-1:0]       r_hint, n_hint;
    logic [7:0]          r_bpo;
    logic [BIN_TOTAL-1:0] r_valid;
    logic                r_hv;
    logic                r_retry, n_retry;
    logic                r_pop2, n_pop2;
    logic [1:0]          r_kind, n_kind;
    logic                r_contig, n_contig;
    logic [MW-1:0]       r_msu, n_msu;
    logic [MW-1:0]       r_need, n_need;
    logic [BW-1:0]       r_bi, n_bi;
    logic [AW-1:0]       r_h, n_h;
    logic [AW-1:0]       r_s, n_s;
    logic                r_pc, n_pc;
    logic [MW-1:0]       r_p, n_p;
    logic [AW-1:0]       r_first, n_first;
    logic [AW-1:0]       r_best, n_best;
    logic [AW-1:0]       r_best_sz, n_best_sz;
    logic [AW-1:0]       r_ts_p, n_ts_p;
    logic [AW-1:0]       r_ts_bs, n_ts_bs;
    logic                r_ts_pc, n_ts_pc;
    logic [AW-1:0]       r_lp, n_lp;
    logic [AW-1:0]       r_lru, n_lru;
    logic [AW-1:0]       r_rp, n_rp;
    logic [AW-1:0]       r_rend, n_rend;
    logic [AW-1:0]       r_np, n_np;
    logic [AW-1:0]       r_ne, n_ne;
    logic                r_pf, n_pf;
    logic                r_nf, n_nf;
    logic                r_rl_co, n_rl_co;
    t_tag                r_prev, n_prev;
    logic [2:0]          r_wcnt, n_wcnt;
    t_res                r_res, n_res;
    logic                valid_set;
    logic [BW-1:0]       valid_idx;

    // scan datapath
    logic [AW-1:0]       bs;
    logic [MW-1:0]       bs13;
    logic                sc_free;
    logic [AW-1:0]       sc_first;
    logic [AW-1:0]       sc_pend;
    logic [7:0]          sc_off;
    logic [8:0]          sc_ru;
    logic [8:0]          sc_ru2;
    logic [AW-1:0]       sc_bsm2;
    logic [7:0]          sc_off2;
    logic [8:0]          sc_rem2;
    logic                sc_lead;
    // take datapath
    logic                ts_split;
    logic [AW-1:0]       ts_e;
    logic [AW-1:0]       ts_end;
    logic [AW-1:0]       ts_rem;
    logic [MW-1:0]       msu_in;
    logic [BW-1:0]       bin_in;
    logic [AW-1:0]       h_sel;
    logic [BW-1:0]       co_sz;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    assign bs       = i_tag_q.size;
    assign bs13     = {1'b0, bs};
    assign sc_free  = (i_tag_q.st == TS_FREE);
    assign sc_first = (r_first == '0) ? r_p[AW-1:0] : r_first;
    assign sc_pend  = r_p[AW] ? AW'(ARENA_UNITS - 1) : r_p[AW-1:0];
    assign sc_off   = r_bpo + r_p[7:0] + 8'd1;
    assign sc_ru    = 9'(PAGE_UNITS) - {1'b0, sc_off};
    assign sc_ru2   = (sc_ru < 9'(LEAD_MIN)) ? 9'(LEAD_MIN) : sc_ru;
    assign sc_bsm2  = bs - AW'(2);
    assign sc_off2  = sc_off + sc_ru2[7:0];
    assign sc_rem2  = 9'(PAGE_UNITS) - {1'b0, sc_off2};
    assign sc_lead  = (sc_bsm2 > {3'b0, sc_ru2})
                   && ({1'b0, sc_bsm2 - {3'b0, sc_ru2}} >= r_msu)
                   && ({4'b0, sc_rem2} >= r_msu);

    assign ts_split = ({1'b0, r_ts_bs} > (r_need + MW'(SPLIT_SLACK)));
    assign ts_e     = r_ts_p + r_need[AW-1:0] - AW'(1);
    assign ts_end   = r_ts_p + r_ts_bs - AW'(1);
    assign ts_rem   = r_ts_bs - r_need[AW-1:0];

    assign msu_in = MW'(({1'b0, i_req.bytes} + 17'd15) >> UB_SHIFT);
    assign bin_in = i_req.contig ? BW'(msu_in + MW'(NUM_BINS - 1)) : BW'(msu_in - MW'(1));
    assign h_sel  = r_hv ? i_head_q : '0;
    assign co_sz  = ((r_bi >= BW'(NUM_BINS)) ? (r_bi - BW'(NUM_BINS)) : r_bi) + BW'(3);

    always_comb begin
        n_state   = r_state;   n_clr    = r_clr;     n_hint  = r_hint;
        n_retry   = r_retry;   n_pop2   = r_pop2;    n_kind  = r_kind;
        n_contig  = r_contig;  n_msu    = r_msu;     n_need  = r_need;
        n_bi      = r_bi;      n_h      = r_h;       n_s     = r_s;
        n_pc      = r_pc;      n_p      = r_p;       n_first = r_first;
        n_best    = r_best;    n_best_sz = r_best_sz;
        n_ts_p    = r_ts_p;    n_ts_bs  = r_ts_bs;   n_ts_pc = r_ts_pc;
        n_lp      = r_lp;      n_lru    = r_lru;     n_rp    = r_rp;
        n_rend    = r_rend;    n_np     = r_np;      n_ne    = r_ne;
        n_pf      = r_pf;      n_nf     = r_nf;      n_rl_co = r_rl_co;
        n_prev    = r_prev;    n_wcnt   = r_wcnt;    n_res   = r_res;
        valid_set = 1'b0;      valid_idx = r_bi;
        o_tag_cmd  = '0;
        o_link_cmd = '0;
        o_head_cmd = '0;

        case (r_state)
            S_CLEAR: begin
                o_tag_cmd.we = 1'b1;
                o_tag_cmd.wa = r_clr;
                o_tag_cmd.wd = tag_reset(r_clr);
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(ARENA_UNITS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_kind   = i_req.kind;
                    n_contig = i_req.contig;
                    n_msu    = msu_in;
                    n_need   = msu_in + MW'(2);
                    n_retry  = 1'b0;
                    n_res    = '{status: STAT_BAD, data: '0, usable: '0};
                    n_state  = S_DONE;
                    case (i_req.kind)
                        KIND_ALLOC: begin
                            if (msu_in == '0) begin
                                n_state = S_DONE;
                            end else if (msu_in <= MW'(NUM_BINS)) begin
                                n_bi  = bin_in;
                                n_pop2 = !i_req.contig;
                                o_head_cmd.re = 1'b1;
                                o_head_cmd.ra = bin_in;
                                n_state = S_POP_H;
                            end else begin
                                n_state = S_SC_INIT;
                            end
                        end
                        KIND_FREE, KIND_QUERY: begin
                            if (i_req.addr >= AW'(2)) begin
                                n_rp = i_req.addr - AW'(1);
                                o_tag_cmd.re = 1'b1;
                                o_tag_cmd.ra = i_req.addr - AW'(1);
                                n_state = S_V_P;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            // lookaside pop
            S_POP_H: begin
                if (h_sel != '0) begin
                    n_h = h_sel;
                    o_link_cmd.re = 1'b1;
                    o_link_cmd.ra = h_sel;
                    n_state = S_POP_L;
                end else if (r_pop2) begin
                    n_pop2 = 1'b0;
                    n_bi   = r_bi + BW'(NUM_BINS);
                    o_head_cmd.re = 1'b1;
                    o_head_cmd.ra = r_bi + BW'(NUM_BINS);
                end else begin
                    n_state = S_SC_INIT;
                end
            end
            S_POP_L: begin
                o_head_cmd.we = 1'b1;
                o_head_cmd.wa = r_bi;
                o_head_cmd.wd = i_link_q;
                o_tag_cmd.re  = 1'b1;
                o_tag_cmd.ra  = r_h;
                n_state = S_POP_T;
            end
            S_POP_T: begin
                o_tag_cmd.we = 1'b1;
                o_tag_cmd.wa = r_h;
                o_tag_cmd.wd = mk_tag(i_tag_q.pc, TS_ALLOC, i_tag_q.size);
                n_s = i_tag_q.size;
                n_state = S_POP_E;
            end
            S_POP_E: begin
                if (({1'b0, r_h} + r_need - MW'(1)) < MW'(ARENA_UNITS)) begin
                    o_tag_cmd.we = 1'b1;
                    o_tag_cmd.wa = r_h + r_need[AW-1:0] - AW'(1);
                    o_tag_cmd.wd = mk_tag(1'b0, TS_ALLOC, r_need[AW-1:0]);
                end
                n_res   = '{status: STAT_OK, data: r_h + AW'(1), usable: usable_of(r_s)};
                n_state = S_DONE;
            end
            // span scan from the hint
            S_SC_INIT: begin
                if (r_contig && r_msu > MW'(PAGE_UNITS)) begin
                    n_state = S_FAIL;
                end else begin
                    n_p     = {1'b0, r_hint};
                    n_first = '0;
                    n_best  = '0;
                    o_tag_cmd.re = 1'b1;
                    o_tag_cmd.ra = r_hint;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_p = r_p + bs13;
                o_tag_cmd.re = 1'b1;
                o_tag_cmd.ra = r_p[AW-1:0] + bs;
                if (r_p[AW] || bs == '0) begin
                    o_tag_cmd.re = 1'b0;
                    n_hint = (r_first != '0) ? r_first : sc_pend;
                    if (!r_contig && r_best != '0) begin
                        n_ts_p  = r_best;
                        n_ts_bs = r_best_sz;
                        n_ts_pc = 1'b0;
                        n_state = S_TS0;
                    end else begin
                        n_state = S_FAIL;
                    end
                end else if (sc_free) begin
                    n_first = sc_first;
                    if (!r_contig) begin
                        if (bs13 == r_need) begin
                            o_tag_cmd.re = 1'b0;
                            n_hint  = sc_first;
                            n_ts_p  = r_p[AW-1:0];
                            n_ts_bs = bs;
                            n_ts_pc = 1'b0;
                            n_state = S_TS0;
                        end else if (bs13 > r_need && (r_best == '0 || bs < r_best_sz)) begin
                            n_best    = r_p[AW-1:0];
                            n_best_sz = bs;
                        end
                    end else if (bs13 >= r_need) begin
                        if ({4'b0, sc_ru} >= r_msu) begin
                            o_tag_cmd.re = 1'b0;
                            n_hint  = sc_first;
                            n_ts_p  = r_p[AW-1:0];
                            n_ts_bs = bs;
                            n_ts_pc = 1'b1;
                            n_state = S_TS0;
                        end else if (sc_lead) begin
                            // split off a leading free fragment
                            o_tag_cmd.re = 1'b0;
                            n_hint  = sc_first;
                            n_lp    = r_p[AW-1:0];
                            n_lru   = {3'b0, sc_ru2};
                            n_ts_p  = r_p[AW-1:0] + {3'b0, sc_ru2};
                            n_ts_bs = bs - {3'b0, sc_ru2};
                            n_ts_pc = 1'b1;
                            n_state = S_LEAD0;
                        end
                    end
                end
            end
            S_FAIL: begin
                if (!r_retry) begin
                    n_retry = 1'b1;
                    n_bi    = '0;
                    o_head_cmd.re = 1'b1;
                    o_head_cmd.ra = '0;
                    n_state = S_CO_H;
                end else begin
                    n_res   = '{status: STAT_NOMEM, data: '0, usable: '0};
                    n_state = S_DONE;
                end
            end
            S_LEAD0: begin
                o_tag_cmd.we = 1'b1;
                o_tag_cmd.wa = r_ts_p - AW'(1);
                o_tag_cmd.wd = mk_tag(1'b0, TS_FREE, r_lru);
                n_state = S_LEAD1;
            end
            S_LEAD1: begin
                o_tag_cmd.we = 1'b1;
                o_tag_cmd.wa = r_lp;
                o_tag_cmd.wd = mk_tag(1'b0, TS_FREE, r_lru);
                n_state = S_TS0;
            end
            // take a span, splitting off the tail when enough is left
            S_TS0: begin
                o_tag_cmd.we = 1'b1;
                o_tag_cmd.wa = ts_end;
                o_tag_cmd.wd = ts_split ? mk_tag(1'b0, TS_FREE, ts_rem)
                                        : mk_tag(1'b0, TS_ALLOC, r_ts_bs);
                n_state = S_TS1;
            end
            S_TS1: begin
                o_tag_cmd.we = 1'b1;
                if (ts_split) begin
                    o_tag_cmd.wa = ts_e + AW'(1);
                    o_tag_cmd.wd = mk_tag(1'b0, TS_FREE, ts_rem);
                    n_state = S_TS2;
                end else begin
                    o_tag_cmd.wa = r_ts_p;
                    o_tag_cmd.wd = mk_tag(r_ts_pc, TS_ALLOC, r_ts_bs);
                    n_res   = '{status: STAT_OK, data: r_ts_p + AW'(1),
                                usable: usable_of(r_ts_bs)};
                    n_state = S_DONE;
                end
            end
            S_TS2: begin
                o_tag_cmd.we = 1'b1;
                o_tag_cmd.wa = ts_e;
                o_tag_cmd.wd = mk_tag(1'b0, TS_ALLOC, r_need[AW-1:0]);
                n_state = S_TS3;
            end
            S_TS3: begin
                o_tag_cmd.we = 1'b1;
                o_tag_cmd.wa = r_ts_p;
                o_tag_cmd.wd = mk_tag(r_ts_pc, TS_ALLOC, r_need[AW-1:0]);
                n_res   = '{status: STAT_OK, data: r_ts_p + AW'(1),
                            usable: usable_of(r_need[AW-1:0])};
                n_state = S_DONE;
            end
            // drain every bin back into the arena
            S_CO_H: begin
                if (h_sel != '0) begin
                    n_h = h_sel;
                    o_link_cmd.re = 1'b1;
                    o_link_cmd.ra = h_sel;
                    n_state = S_CO_L;
                end else if (r_bi == BW'(BIN_TOTAL - 1)) begin
                    n_hint  = AW'(1);
                    n_state = S_SC_INIT;
                end else begin
                    n_bi = r_bi + BW'(1);
                    o_head_cmd.re = 1'b1;
                    o_head_cmd.ra = r_bi + BW'(1);
                end
            end
            S_CO_L: begin
                o_head_cmd.we = 1'b1;
                o_head_cmd.wa = r_bi;
                o_head_cmd.wd = i_link_q;
                n_rp    = r_h;
                n_rend  = r_h + {{(AW-BW){1'b0}}, co_sz} - AW'(1);
                n_rl_co = 1'b1;
                n_state = S_RL0;
            end
            // release: merge with free neighbors
            S_RL0: begin
                o_tag_cmd.re = 1'b1;
                o_tag_cmd.ra = r_rp - AW'(1);
                n_state = S_RL1;
            end
            S_RL1: begin
                n_prev = i_tag_q;
                o_tag_cmd.re = 1'b1;
                o_tag_cmd.ra = r_rend + AW'(1);
                n_state = S_RL2;
            end
            S_RL2: begin
                n_pf   = (r_prev.st == TS_FREE);
                n_nf   = (i_tag_q.st == TS_FREE);
                n_np   = (r_prev.st == TS_FREE) ? (r_rp - r_prev.size) : r_rp;
                n_ne   = (i_tag_q.st == TS_FREE) ? (r_rend + i_tag_q.size) : r_rend;
                n_wcnt = '0;
                n_state = S_RLW;
            end
            S_RLW: begin
                n_wcnt = r_wcnt + 3'd1;
                o_tag_cmd.wd = mk_tag(1'b0, TS_FREE, '0);
                case (r_wcnt)
                    3'd0: begin
                        o_tag_cmd.we = r_pf;
                        o_tag_cmd.wa = r_rp - AW'(1);
                    end
                    3'd1: begin
                        o_tag_cmd.we = r_pf;
                        o_tag_cmd.wa = r_rp;
                    end
                    3'd2: begin
                        o_tag_cmd.we = r_nf;
                        o_tag_cmd.wa = r_rend;
                    end
                    3'd3: begin
                        o_tag_cmd.we = r_nf;
                        o_tag_cmd.wa = r_rend + AW'(1);
                    end
                    3'd4: begin
                        o_tag_cmd.we = 1'b1;
                        o_tag_cmd.wa = r_np;
                        o_tag_cmd.wd = mk_tag(1'b0, TS_FREE, r_ne + AW'(1) - r_np);
                    end
                    default: begin
                        o_tag_cmd.we = 1'b1;
                        o_tag_cmd.wa = r_ne;
                        o_tag_cmd.wd = mk_tag(1'b0, TS_FREE, r_ne + AW'(1) - r_np);
                        if (r_rl_co) begin
                            o_head_cmd.re = 1'b1;
                            o_head_cmd.ra = r_bi;
                            n_state = S_CO_H;
                        end else begin
                            if (r_hint > r_rp) begin
                                n_hint = r_rp;
                            end
                            n_state = S_DONE;
                        end
                    end
                endcase
            end
            // free and query: check both tags and the unit before
            S_V_P: begin
                n_s  = i_tag_q.size;
                n_pc = i_tag_q.pc;
                if (i_tag_q.st == TS_ALLOC && i_tag_q.size >= AW'(3)
                        && i_tag_q.size <= (AW'(ARENA_UNITS - 1) - r_rp)) begin
                    o_tag_cmd.re = 1'b1;
                    o_tag_cmd.ra = r_rp + i_tag_q.size - AW'(1);
                    n_state = S_V_E;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_V_E: begin
                if (i_tag_q.st == TS_ALLOC && i_tag_q.size == r_s) begin
                    o_tag_cmd.re = 1'b1;
                    o_tag_cmd.ra = r_rp - AW'(1);
                    n_state = S_V_B;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_V_B: begin
                n_state = S_DONE;
                if (i_tag_q.size != '0) begin
                    n_res = '{status: STAT_OK, data: '0, usable: usable_of(r_s)};
                    if (r_kind == KIND_FREE) begin
                        if (r_s <= AW'(NUM_BINS + 2)) begin
                            n_bi = BW'(r_s - AW'(3)) + (r_pc ? BW'(NUM_BINS) : BW'(0));
                            o_head_cmd.re = 1'b1;
                            o_head_cmd.ra = BW'(r_s - AW'(3)) + (r_pc ? BW'(NUM_BINS) : BW'(0));
                            n_state = S_F_H;
                        end else begin
                            n_rend  = r_rp + r_s - AW'(1);
                            n_rl_co = 1'b0;
                            n_state = S_RL0;
                        end
                    end
                end
            end
            S_F_H: begin
                o_link_cmd.we = 1'b1;
                o_link_cmd.wa = r_rp;
                o_link_cmd.wd = h_sel;
                o_tag_cmd.we  = 1'b1;
                o_tag_cmd.wa  = r_rp;
                o_tag_cmd.wd  = mk_tag(r_pc, TS_BIN, r_s);
                n_state = S_F_E;
            end
            S_F_E: begin
                o_tag_cmd.we  = 1'b1;
                o_tag_cmd.wa  = r_rp + r_s - AW'(1);
                o_tag_cmd.wd  = mk_tag(1'b0, TS_BIN, r_s);
                o_head_cmd.we = 1'b1;
                o_head_cmd.wa = r_bi;
                o_head_cmd.wd = r_rp;
                valid_set = 1'b1;
                valid_idx = r_bi;
                n_state = S_DONE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_hint  <= AW'(1);
            r_bpo   <= '0;
            r_valid <= '0;
            r_retry <= 1'b0;
            r_pop2  <= 1'b0;
            r_wcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_hint  <= n_hint;
            r_retry <= n_retry;
            r_pop2  <= n_pop2;
            r_wcnt  <= n_wcnt;
            if (i_cfg_we) begin
                r_bpo <= i_cfg_wdata;
            end
            if (valid_set) begin
                r_valid[valid_idx] <= 1'b1;
            end
        end
        // a head entry that was never written reads as an empty bin
        r_hv      <= r_valid[o_head_cmd.ra];
        r_kind    <= n_kind;    r_contig  <= n_contig;  r_msu   <= n_msu;
        r_need    <= n_need;    r_bi      <= n_bi;      r_h     <= n_h;
        r_s       <= n_s;       r_pc      <= n_pc;      r_p     <= n_p;
        r_first   <= n_first;   r_best    <= n_best;    r_best_sz <= n_best_sz;
        r_ts_p    <= n_ts_p;    r_ts_bs   <= n_ts_bs;   r_ts_pc <= n_ts_pc;
        r_lp      <= n_lp;      r_lru     <= n_lru;     r_rp    <= n_rp;
        r_rend    <= n_rend;    r_np      <= n_np;      r_ne    <= n_ne;
        r_pf      <= n_pf;      r_nf      <= n_nf;      r_rl_co <= n_rl_co;
        r_prev    <= n_prev;    r_res     <= n_res;
    end
endmodule
`default_nettype wire

@@ hw/rtl/boundary_tag_heap_allocator_core.sv @@
// Boundary-tag heap allocator: top level with stream ports and output register.
// A request is served by a bin pop (the second bin too for non-contiguous requests)
// or by a scan that walks the spans and then takes one; coalescing drains each bin
// and releases every binned span. A small free goes into a bin, a large one is released.
// One request at a time. Reset is synchronous; afterwards a pass over every unit clears
// the tag memory and no request is accepted until it ends.
`default_nettype none
module boundary_tag_heap_allocator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,  // request_bytes[15:0], contiguous, block_address[11:0]
    input  wire logic [1:0]  i_s_tuser,  // kind
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [31:0] o_m_tdata,  // data_address[11:0], usable_bytes[15:0]
    output logic      [1:0]  o_m_tuser,  // status
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata
);
    import bta_pkg::*;

    t_req       req;
    t_res       res;
    logic       res_valid;
    logic       res_ready;
    t_tag_cmd   tag_cmd;
    t_link_cmd  link_cmd;
    t_head_cmd  head_cmd;
    t_tag       tag_q;
    logic [14:0] tag_rd;
    logic [11:0] link_q;
    logic [11:0] head_q;
    logic       r_out_valid;
    t_res       r_out;

    assign req.kind   = i_s_tuser;
    assign req.bytes  = i_s_tdata[15:0];
    assign req.contig = i_s_tdata[16];
    assign req.addr   = i_s_tdata[28:17];
    assign tag_q      = t_tag'(tag_rd);

    // hold the result until taken; the sequencer waits only while it is full
    assign res_ready = !r_out_valid || i_m_tready;

    bta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req       (req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_tag_cmd   (tag_cmd),
        .i_tag_q     (tag_q),
        .o_link_cmd  (link_cmd),
        .i_link_q    (link_q),
        .o_head_cmd  (head_cmd),
        .i_head_q    (head_q)
    );

    bta_ram #(.W(15), .D(ARENA_UNITS)) u_tag_ram (
        .i_clk (i_clk),
        .i_we  (tag_cmd.we),
        .i_wa  (tag_cmd.wa),
        .i_wd  (tag_cmd.wd),
        .i_re  (tag_cmd.re),
        .i_ra  (tag_cmd.ra),
        .o_rd  (tag_rd)
    );

    bta_ram #(.W(AW), .D(ARENA_UNITS)) u_link_ram (
        .i_clk (i_clk),
        .i_we  (link_cmd.we),
        .i_wa  (link_cmd.wa),
        .i_wd  (link_cmd.wd),
        .i_re  (link_cmd.re),
        .i_ra  (link_cmd.ra),
        .o_rd  (link_q)
    );

    bta_ram #(.W(AW), .D(BIN_TOTAL), .A(BW)) u_head_ram (
        .i_clk (i_clk),
        .i_we  (head_cmd.we),
        .i_wa  (head_cmd.wa),
        .i_wd  (head_cmd.wd),
        .i_re  (head_cmd.re),
        .i_ra  (head_cmd.ra),
        .o_rd  (head_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = {4'b0, r_out.usable, r_out.data};
endmodule
`default_nettype wire
